### rtl/bnpe_pkg.sv
// ----------------------------------------------------------------------------
// bnpe_pkg: shared definitions for the base-n peer enumerator
// Field widths, configuration register codes and reset values, the power
// record used by the power table and the pipeline, and one remainder step.
// ----------------------------------------------------------------------------
package bnpe_pkg;

	localparam int ID_W       = 32;
	localparam int LEVEL_W    = 3;
	localparam int RANK_W     = 4;
	localparam int RADIX_W    = 5;
	localparam int DCOUNT_W   = 4;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 5;

	localparam int MAX_DIGITS_DEF = 8;
	localparam int MAX_RADIX_DEF  = 16;

	localparam logic [CFG_IDX_W-1:0] REG_RADIX       = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_DIGIT_COUNT = 1'b1;

	localparam logic [RADIX_W-1:0]  RADIX_RST  = 5'd4;
	localparam logic [DCOUNT_W-1:0] DIGITS_RST = 4'd2;

	// A power of the radix kept modulo 2^32, with a flag that is set when the
	// true value has reached 2^32 or more.
	typedef struct packed {
		logic            big;
		logic [ID_W-1:0] value;
	} pow_t;

	// One step of a restoring remainder: shift in the next dividend bit and
	// subtract the divisor when it fits. A divisor that is too large never fits.
	function automatic logic [ID_W-1:0] div_step(input logic [ID_W-1:0] rem,
		input logic din, input pow_t divisor);
		logic [ID_W:0] t;
		t = {rem, din};
		if (!divisor.big && (t >= {1'b0, divisor.value})) begin
			t = t - {1'b0, divisor.value};
		end
		return t[ID_W-1:0];
	endfunction

endpackage

### rtl/bnpe_pow_table.sv
// ----------------------------------------------------------------------------
// bnpe_pow_table: table of radix powers
// After reset and after every configuration write, sweeps radix^0 through
// radix^MAX_DIGITS, one multiply per cycle, and keeps radix^digit_count apart.
// ----------------------------------------------------------------------------
module bnpe_pow_table #(
	parameter int MAX_DIGITS = bnpe_pkg::MAX_DIGITS_DEF,
	parameter int MAX_RADIX  = bnpe_pkg::MAX_RADIX_DEF,
	localparam int NW = $clog2(MAX_RADIX + 1),
	localparam int KW = $clog2(MAX_DIGITS + 1)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          restart,
	input  logic [NW-1:0]                 radix_n,
	input  logic [KW-1:0]                 digits_k,
	input  logic [bnpe_pkg::LEVEL_W-1:0]  lvl,
	output logic                          busy,
	output bnpe_pkg::pow_t                w_sel,
	output bnpe_pkg::pow_t                pk
);
	import bnpe_pkg::*;

	logic            busy_q;
	logic [KW-1:0]   idx_q;
	pow_t            cur_q;
	pow_t            next_pow;
	pow_t            tab_q [MAX_DIGITS];
	pow_t            pk_q;
	logic [ID_W+NW-1:0] prod;

	always_comb begin
		prod           = (ID_W + NW)'(cur_q.value) * (ID_W + NW)'(radix_n);
		next_pow.value = prod[ID_W-1:0];
		next_pow.big   = cur_q.big | (|prod[ID_W+NW-1:ID_W]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b1;
			idx_q     <= '0;
			cur_q     <= '{big: 1'b0, value: ID_W'(1)};
		end else if (restart) begin
			busy_q    <= 1'b1;
			idx_q     <= '0;
			cur_q     <= '{big: 1'b0, value: ID_W'(1)};
		end else if (busy_q) begin
			cur_q <= next_pow;
			if (idx_q == KW'(MAX_DIGITS)) begin
				busy_q <= 1'b0;
			end else begin
				idx_q <= idx_q + KW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q && !restart) begin
			for (int j = 0; j < MAX_DIGITS; j++) begin
				if (idx_q == KW'(j)) begin
					tab_q[j] <= cur_q;
				end
			end
			if (idx_q == digits_k) begin
				pk_q <= cur_q;
			end
		end
	end

	always_comb begin
		w_sel = '{big: 1'b0, value: '0};
		for (int j = 0; j < MAX_DIGITS; j++) begin
			if (int'(lvl) == j) begin
				w_sel = tab_q[j];
			end
		end
	end

	assign busy = busy_q;
	assign pk   = pk_q;

endmodule

### rtl/bnpe_emitter.sv
// ----------------------------------------------------------------------------
// bnpe_emitter: peer sequencer and output register
// Holds one prepared item and steps the replacing digit, adding the level
// weight each time and jumping over the node's own digit.
// ----------------------------------------------------------------------------
module bnpe_emitter #(
	parameter int RW = 4
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         load,
	input  logic [bnpe_pkg::ID_W-1:0]    ld_acc,
	input  logic [bnpe_pkg::ID_W-1:0]    ld_w,
	input  logic [RW-1:0]                ld_own,
	input  logic                         ld_err,
	input  logic [RW-1:0]                n_max,
	output logic                         can_take,
	input  logic                         out_stall,
	output logic                         out_valid,
	output logic [bnpe_pkg::ID_W-1:0]    peer_id,
	output logic [bnpe_pkg::RANK_W-1:0]  peer_rank,
	output logic                         last,
	output logic                         level_error
);
	import bnpe_pkg::*;

	logic                busy_q;
	logic [ID_W-1:0]     acc_q;
	logic [ID_W-1:0]     w_q;
	logic [RW-1:0]       r_q;
	logic [RW-1:0]       own_q;
	logic                err_q;
	logic [RANK_W-1:0]   rank_q;

	logic                out_valid_q;
	logic [ID_W-1:0]     peer_id_q;
	logic [RANK_W-1:0]   peer_rank_q;
	logic                last_q;
	logic                level_error_q;

	logic                out_space;
	logic                emit;
	logic                cur_last;
	logic [RW:0]         r_inc;
	logic                skip;
	logic [RW-1:0]       r_next;
	logic [ID_W-1:0]     acc_next;

	always_comb begin
		out_space = !out_valid_q || !out_stall;
		emit      = busy_q && out_space;
		r_inc     = {1'b0, r_q} + (RW + 1)'(1);
		cur_last  = err_q || (r_q == n_max) ||
			((r_inc == {1'b0, n_max}) && (own_q == n_max));
		skip      = (r_inc == {1'b0, own_q});
		r_next    = skip ? RW'(r_inc + (RW + 1)'(1)) : r_inc[RW-1:0];
		acc_next  = acc_q + (skip ? {w_q[ID_W-2:0], 1'b0} : w_q);
		can_take  = !busy_q || (emit && cur_last);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				busy_q <= 1'b1;
			end else if (emit && cur_last) begin
				busy_q <= 1'b0;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			peer_id_q     <= err_q ? '0 : acc_q;
			peer_rank_q   <= rank_q;
			last_q        <= cur_last;
			level_error_q <= err_q;
		end
		if (load) begin
			acc_q  <= ld_acc;
			w_q    <= ld_w;
			own_q  <= ld_own;
			err_q  <= ld_err;
			r_q    <= (ld_own == '0) ? RW'(1) : '0;
			rank_q <= '0;
		end else if (emit && !cur_last) begin
			acc_q  <= acc_next;
			r_q    <= r_next;
			rank_q <= rank_q + RANK_W'(1);
		end
	end

	assign out_valid   = out_valid_q;
	assign peer_id     = peer_id_q;
	assign peer_rank   = peer_rank_q;
	assign last        = last_q;
	assign level_error = level_error_q;

endmodule

### rtl/base_n_peer_enumerator_top.sv
// ----------------------------------------------------------------------------
// base_n_peer_enumerator_top: mixed-radix peer enumerator
// Splits a node number into digit_count base-radix digits and emits every
// node that differs from it only in the digit at the requested level.
// ----------------------------------------------------------------------------
// Each input transaction carries a node number and a level. The node number
// is reduced modulo radix^digit_count, and the block then delivers radix-1
// result transactions, one for each replacing digit other than the node's own
// digit at that level, in increasing order of that digit, numbered by
// peer_rank from zero and with last set on the final one. A level at or above
// digit_count gives a single result with level_error and last set and a peer
// of zero. The output channel moves one result per cycle while out_stall is
// low, and the sequencer in front of the output register takes the next item
// in the same cycle that it hands out the final result of the current one.
// From input to first result an item passes a capture stage, a multiply
// stage for radix^(level+1), a 32-step restoring remainder pipeline, one
// stage per quotient bit to find the node's own digit, and a multiply and an
// add stage. After reset and after every configuration write the block
// rebuilds its table of radix powers, and holds in_stall high meanwhile.
// Configuration must only be written while no transaction is in flight.
// Radix values outside 2..MAX_RADIX are clamped to that range, and
// digit_count is clamped to MAX_DIGITS.
// ----------------------------------------------------------------------------
module base_n_peer_enumerator_top #(
	parameter int MAX_DIGITS = bnpe_pkg::MAX_DIGITS_DEF,
	parameter int MAX_RADIX  = bnpe_pkg::MAX_RADIX_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// Configuration write port.
	input  logic                            cfg_we,
	input  logic [bnpe_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bnpe_pkg::CFG_DATA_W-1:0] cfg_wdata,
	// Input channel.
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [bnpe_pkg::ID_W-1:0]       node_id,
	input  logic [bnpe_pkg::LEVEL_W-1:0]    level,
	// Output channel.
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [bnpe_pkg::ID_W-1:0]       peer_id,
	output logic [bnpe_pkg::RANK_W-1:0]     peer_rank,
	output logic                            last,
	output logic                            level_error
);
	import bnpe_pkg::*;

	localparam int NW        = $clog2(MAX_RADIX + 1);
	localparam int KW        = $clog2(MAX_DIGITS + 1);
	localparam int RW        = $clog2(MAX_RADIX);
	localparam int DIV_STEPS = ID_W;

	// Configuration registers and their clamped views.
	logic [RADIX_W-1:0]  radix_q;
	logic [DCOUNT_W-1:0] digit_count_q;
	logic [NW-1:0]       n_eff;
	logic [KW-1:0]       k_eff;
	logic [RW-1:0]       n_max;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q       <= RADIX_RST;
			digit_count_q <= DIGITS_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_RADIX:       radix_q       <= cfg_wdata[RADIX_W-1:0];
				REG_DIGIT_COUNT: digit_count_q <= cfg_wdata[DCOUNT_W-1:0];
			endcase
		end
	end

	always_comb begin
		if (int'(radix_q) < 2) begin
			n_eff = NW'(2);
		end else if (int'(radix_q) > MAX_RADIX) begin
			n_eff = NW'(MAX_RADIX);
		end else begin
			n_eff = NW'(radix_q);
		end
		if (int'(digit_count_q) > MAX_DIGITS) begin
			k_eff = KW'(MAX_DIGITS);
		end else begin
			k_eff = KW'(digit_count_q);
		end
		n_max = RW'(n_eff - NW'(1));
	end

	// Power table: radix^level is looked up by the incoming level, and
	// radix^digit_count is the modulus read directly by the remainder stages.
	// The user, not the block, keeps both fixed while transactions are in flight.
	logic tab_busy;
	pow_t w_sel;
	pow_t pk;

	bnpe_pow_table #(
		.MAX_DIGITS (MAX_DIGITS),
		.MAX_RADIX  (MAX_RADIX)
	) u_pow (
		.clk      (clk),
		.arst_n   (arst_n),
		.restart  (cfg_we),
		.radix_n  (n_eff),
		.digits_k (k_eff),
		.lvl      (level),
		.busy     (tab_busy),
		.w_sel    (w_sel),
		.pk       (pk)
	);

	// The whole pipeline moves together; it holds only when the last stage
	// has an item that the sequencer cannot take yet.
	logic pipe_en;
	logic em_can_take;
	logic v_s6;

	assign pipe_en  = !v_s6 || em_can_take;
	assign in_stall = tab_busy || !pipe_en;

	// Stage 1: capture the transaction, look up the level weight and check
	// the level against the digit count.
	logic            v_s1;
	logic [ID_W-1:0] val_s1;
	pow_t            w_s1;
	logic            err_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (pipe_en) begin
			v_s1 <= in_valid && !tab_busy;
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			val_s1 <= node_id;
			w_s1   <= w_sel;
			err_s1 <= int'(level) >= int'(k_eff);
		end
	end

	// Stage 2: radix^(level+1), the modulus that isolates the low digits up
	// to and including the level digit.
	logic              v_s2;
	logic [ID_W-1:0]   val_s2;
	pow_t              w_s2;
	pow_t              wn_s2;
	logic              err_s2;
	logic [ID_W+NW-1:0] wn_prod;

	assign wn_prod = (ID_W + NW)'(w_s1.value) * (ID_W + NW)'(n_eff);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (pipe_en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			val_s2       <= val_s1;
			w_s2         <= w_s1;
			wn_s2.value  <= wn_prod[ID_W-1:0];
			wn_s2.big    <= w_s1.big | (|wn_prod[ID_W+NW-1:ID_W]);
			err_s2       <= err_s1;
		end
	end

	// Stage group 3: two restoring remainders side by side, one dividend bit
	// per stage, most significant bit first. Lane a gives the node number
	// modulo radix^digit_count, lane b modulo radix^(level+1).
	logic            v_s3   [DIV_STEPS];
	logic [ID_W-1:0] val_s3 [DIV_STEPS];
	logic [ID_W-1:0] ra_s3  [DIV_STEPS];
	logic [ID_W-1:0] rb_s3  [DIV_STEPS];
	pow_t            w_s3   [DIV_STEPS];
	pow_t            wn_s3  [DIV_STEPS];
	logic            err_s3 [DIV_STEPS];

	for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
		logic            v_in;
		logic [ID_W-1:0] val_in;
		logic [ID_W-1:0] ra_in;
		logic [ID_W-1:0] rb_in;
		pow_t            w_in;
		pow_t            wn_in;
		logic            err_in;

		if (j == 0) begin : g_head
			assign v_in   = v_s2;
			assign val_in = val_s2;
			assign ra_in  = '0;
			assign rb_in  = '0;
			assign w_in   = w_s2;
			assign wn_in  = wn_s2;
			assign err_in = err_s2;
		end else begin : g_body
			assign v_in   = v_s3[j-1];
			assign val_in = val_s3[j-1];
			assign ra_in  = ra_s3[j-1];
			assign rb_in  = rb_s3[j-1];
			assign w_in   = w_s3[j-1];
			assign wn_in  = wn_s3[j-1];
			assign err_in = err_s3[j-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s3[j] <= 1'b0;
			end else if (pipe_en) begin
				v_s3[j] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (pipe_en) begin
				val_s3[j] <= {val_in[ID_W-2:0], 1'b0};
				ra_s3[j]  <= div_step(ra_in, val_in[ID_W-1], pk);
				rb_s3[j]  <= div_step(rb_in, val_in[ID_W-1], wn_in);
				w_s3[j]   <= w_in;
				wn_s3[j]  <= wn_in;
				err_s3[j] <= err_in;
			end
		end
	end

	// Stage group 4: the node's own digit at the level is the quotient of
	// lane b by radix^level, which is below radix; one quotient bit per stage.
	logic            v_s4    [RW];
	logic [ID_W-1:0] rb_s4   [RW];
	logic [RW-1:0]   own_s4  [RW];
	logic [ID_W-1:0] base_s4 [RW];
	pow_t            w_s4    [RW];
	logic            err_s4  [RW];

	for (genvar j = 0; j < RW; j++) begin : g_own
		localparam int BITPOS = RW - 1 - j;

		logic               v_in;
		logic [ID_W-1:0]    rb_in;
		logic [RW-1:0]      own_in;
		logic [ID_W-1:0]    base_in;
		pow_t               w_in;
		logic               err_in;
		logic [ID_W+RW-1:0] trial;
		logic [ID_W+RW-1:0] rb_ext;
		logic               hit;
		logic [RW-1:0]      own_out;

		if (j == 0) begin : g_head
			assign v_in    = v_s3[DIV_STEPS-1];
			assign rb_in   = rb_s3[DIV_STEPS-1];
			assign own_in  = '0;
			assign base_in = ra_s3[DIV_STEPS-1];
			assign w_in    = w_s3[DIV_STEPS-1];
			assign err_in  = err_s3[DIV_STEPS-1];
		end else begin : g_body
			assign v_in    = v_s4[j-1];
			assign rb_in   = rb_s4[j-1];
			assign own_in  = own_s4[j-1];
			assign base_in = base_s4[j-1];
			assign w_in    = w_s4[j-1];
			assign err_in  = err_s4[j-1];
		end

		always_comb begin
			trial   = (ID_W + RW)'(w_in.value) << BITPOS;
			rb_ext  = (ID_W + RW)'(rb_in);
			hit     = !w_in.big && (rb_ext >= trial);
			own_out = own_in;
			own_out[BITPOS] = hit;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s4[j] <= 1'b0;
			end else if (pipe_en) begin
				v_s4[j] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (pipe_en) begin
				rb_s4[j]   <= hit ? ID_W'(rb_ext - trial) : rb_in;
				own_s4[j]  <= own_out;
				base_s4[j] <= base_in;
				w_s4[j]    <= w_in;
				err_s4[j]  <= err_in;
			end
		end
	end

	// Stage 5: weight of the own digit, own * radix^level.
	logic            v_s5;
	logic [ID_W-1:0] base_s5;
	logic [ID_W-1:0] prod_s5;
	logic [ID_W-1:0] w_s5;
	logic [RW-1:0]   own_s5;
	logic            err_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (pipe_en) begin
			v_s5 <= v_s4[RW-1];
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			base_s5 <= base_s4[RW-1];
			prod_s5 <= w_s4[RW-1].value * ID_W'(own_s4[RW-1]);
			w_s5    <= w_s4[RW-1].value;
			own_s5  <= own_s4[RW-1];
			err_s5  <= err_s4[RW-1];
		end
	end

	// Stage 6: clear the level digit and set it to the first replacing digit,
	// which is one when the node's own digit is zero and zero otherwise.
	logic [ID_W-1:0] acc_s6;
	logic [ID_W-1:0] w_s6;
	logic [RW-1:0]   own_s6;
	logic            err_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (pipe_en) begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			acc_s6 <= err_s5 ? '0 :
				base_s5 - prod_s5 + ((own_s5 == '0) ? w_s5 : '0);
			w_s6   <= w_s5;
			own_s6 <= own_s5;
			err_s6 <= err_s5;
		end
	end

	// Sequencer and output register.
	bnpe_emitter #(
		.RW (RW)
	) u_emit (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (v_s6 && em_can_take),
		.ld_acc      (acc_s6),
		.ld_w        (w_s6),
		.ld_own      (own_s6),
		.ld_err      (err_s6),
		.n_max       (n_max),
		.can_take    (em_can_take),
		.out_stall   (out_stall),
		.out_valid   (out_valid),
		.peer_id     (peer_id),
		.peer_rank   (peer_rank),
		.last        (last),
		.level_error (level_error)
	);

endmodule

### rtl/bnpe_checker.sv
// ----------------------------------------------------------------------------
// bnpe_checker: port-level checks for the peer enumerator
// Watches the top level's ports and is attached to it by the bind below.
// ----------------------------------------------------------------------------
module bnpe_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           cfg_we,
	input logic                           in_stall,
	input logic                           out_valid,
	input logic                           out_stall,
	input logic [bnpe_pkg::ID_W-1:0]      peer_id,
	input logic [bnpe_pkg::RANK_W-1:0]    peer_rank,
	input logic                           last,
	input logic                           level_error
);

	// A stalled result transaction keeps its contents.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(peer_id) &&
		$stable(peer_rank) && $stable(last) && $stable(level_error))
		else $error("stalled result changed");

	// A level error is always a single, empty result.
	a_err_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && level_error |-> last && (peer_id == '0) && (peer_rank == '0))
		else $error("malformed level error result");

	// Within one run, results follow each other without gaps and ranks count up.
	a_run_seq: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last |=>
		out_valid && (peer_rank == $past(peer_rank) + 4'd1))
		else $error("run of peers broken");

	// A configuration write rebuilds the power table, so input is held off.
	a_cfg_stall: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> in_stall)
		else $error("input accepted while the power table rebuilds");

endmodule

bind base_n_peer_enumerator_top bnpe_checker u_bnpe_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.cfg_we      (cfg_we),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.peer_id     (peer_id),
	.peer_rank   (peer_rank),
	.last        (last),
	.level_error (level_error)
);
